// ===== sv/sdft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdft_pkg
// Shared sizes, codes and types of the steepest-descent flow tracer.
// ----------------------------------------------------------------------------
package sdft_pkg;

    // Map and trace limits.
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_DEPTH    = 256;
    localparam int MAX_SEGMENTS = 64;

    // Field widths.
    localparam int COORD_W  = 8;
    localparam int HEIGHT_W = 16;
    localparam int DIM_W    = 9;

    // Height store geometry and segment counter width.
    localparam int MAP_CELLS = MAX_WIDTH * MAX_DEPTH;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);

    // Largest usable map size along each axis.
    localparam int LIM_WIDTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int LIM_DEPTH = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

    // Request kinds carried in the input tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TRACE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MAP_WIDTH = 1'b0;
    localparam logic CFG_MAP_DEPTH = 1'b1;

    // Tracer sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // One result item.
    typedef struct packed {
        logic                       segment_valid;
        logic [COORD_W-1:0]         from_x;
        logic [COORD_W-1:0]         from_z;
        logic signed [HEIGHT_W-1:0] from_height;
        logic [COORD_W-1:0]         to_x;
        logic [COORD_W-1:0]         to_z;
        logic signed [HEIGHT_W-1:0] to_height;
        logic                       truncated;
        logic                       last_segment;
    } t_result;

    // Access request from the tracer to the height store.
    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          waddr;
        logic signed [HEIGHT_W-1:0] wdata;
        logic [ADDR_W-1:0]          raddr;
    } t_ram_req;

    // Linear store address of a map cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] z);
        return ADDR_W'(32'(z) * MAX_WIDTH + 32'(x));
    endfunction

endpackage

// ===== sv/sdft_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdft_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sdft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sdft_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdft_core
// Trace sequencer: loads samples, scans neighbor windows through the height
// store read port and builds the result items of a trace.
// ----------------------------------------------------------------------------
module sdft_core
    import sdft_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_req_type,
    input  logic [COORD_W-1:0]         i_x,
    input  logic [COORD_W-1:0]         i_z,
    input  logic signed [HEIGHT_W-1:0] i_height,
    input  logic [DIM_W-1:0]           i_width,
    input  logic [DIM_W-1:0]           i_depth,
    output t_ram_req                   o_ram,
    input  logic signed [HEIGHT_W-1:0] i_ram_rdata,
    output logic                       o_push,
    output t_result                    o_result,
    input  logic                       i_slot_free
);

    t_state r_state, n_state;

    logic                       r_cen, n_cen;
    logic [COORD_W-1:0]         r_sx, n_sx, r_sz, n_sz;
    logic                       r_pv, n_pv, r_pc, n_pc;
    logic [COORD_W-1:0]         r_px, n_px, r_pz, n_pz;
    logic signed [HEIGHT_W-1:0] r_ch, n_ch, r_best, n_best;
    logic                       r_found, n_found;
    logic [COORD_W-1:0]         r_bx, n_bx, r_bz, n_bz;
    logic [COORD_W-1:0]         r_cx, n_cx, r_cz, n_cz;
    logic [COORD_W-1:0]         r_fx, n_fx, r_fz, n_fz;
    logic signed [HEIGHT_W-1:0] r_fh, n_fh;
    logic                       r_first, n_first;
    logic [CNT_W-1:0]           r_count, n_count;
    t_result                    r_res, n_res;
    logic                       r_end, n_end;

    logic               accept_trace;
    logic               start_outside;
    logic [COORD_W-1:0] x0, x1, z0, z1;
    logic               scan_last;
    logic [CNT_W-1:0]   cnt1;
    logic               seg_last;

    // Request decode.
    assign accept_trace  = (r_state == ST_IDLE) && i_in_valid && (i_req_type == REQ_TRACE);
    assign start_outside = ({1'b0, i_x} >= i_width) || ({1'b0, i_z} >= i_depth);

    // Neighbor window of the current cell, clipped to the map.
    assign x0 = (r_cx != '0) ? r_cx - 1'b1 : '0;
    assign z0 = (r_cz != '0) ? r_cz - 1'b1 : '0;
    assign x1 = (({1'b0, r_cx} + 1'b1) < i_width) ? r_cx + 1'b1 : COORD_W'(i_width - 1'b1);
    assign z1 = (({1'b0, r_cz} + 1'b1) < i_depth) ? r_cz + 1'b1 : COORD_W'(i_depth - 1'b1);
    assign scan_last = !r_cen && (r_sx == x1) && (r_sz == z1);

    // Move bookkeeping for a scan that follows a move.
    assign cnt1     = r_count + 1'b1;
    assign seg_last = !n_found || (32'(cnt1) >= MAX_SEGMENTS);

    // Compare stage: fold the sample that returns from the store.
    always_comb begin
        n_ch    = r_ch;
        n_best  = r_best;
        n_found = r_found;
        n_bx    = r_bx;
        n_bz    = r_bz;
        if (r_pc) begin
            n_ch    = i_ram_rdata;
            n_best  = i_ram_rdata;
            n_found = 1'b0;
        end else if (r_pv && (i_ram_rdata < r_best)) begin
            n_best  = i_ram_rdata;
            n_found = 1'b1;
            n_bx    = r_px;
            n_bz    = r_pz;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept_trace) begin
                    n_state = start_outside ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = (r_first && n_found) ? ST_SCAN : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_slot_free) begin
                    n_state = r_end ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_push      = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = cell_addr(i_x, i_z);
        o_ram.wdata = i_height;
        o_ram.raddr = r_cen ? cell_addr(r_cx, r_cz) : cell_addr(r_sx, r_sz);
        o_result    = r_res;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ram.we   = i_in_valid && (i_req_type == REQ_WRITE)
                             && (32'(i_x) < MAX_WIDTH) && (32'(i_z) < MAX_DEPTH);
            end
            ST_EMIT: begin
                o_push = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_cen   = r_cen;
        n_sx    = r_sx;
        n_sz    = r_sz;
        n_pv    = 1'b0;
        n_pc    = 1'b0;
        n_px    = r_sx;
        n_pz    = r_sz;
        n_cx    = r_cx;
        n_cz    = r_cz;
        n_fx    = r_fx;
        n_fz    = r_fz;
        n_fh    = r_fh;
        n_first = r_first;
        n_count = r_count;
        n_res   = r_res;
        n_end   = r_end;
        case (r_state)
            ST_IDLE: begin
                if (accept_trace) begin
                    n_cx    = i_x;
                    n_cz    = i_z;
                    n_first = 1'b1;
                    n_count = '0;
                    n_cen   = 1'b1;
                    if (start_outside) begin
                        n_res              = '0;
                        n_res.from_x       = i_x;
                        n_res.from_z       = i_z;
                        n_res.last_segment = 1'b1;
                        n_end              = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cen) begin
                    // Center read first; it seeds the running minimum.
                    n_pc  = 1'b1;
                    n_cen = 1'b0;
                    n_sx  = x0;
                    n_sz  = z0;
                end else begin
                    n_pv = !((r_sx == r_cx) && (r_sz == r_cz));
                    if (r_sz == z1) begin
                        n_sz = z0;
                        n_sx = r_sx + 1'b1;
                    end else begin
                        n_sz = r_sz + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                n_cen = 1'b1;
                if (r_first) begin
                    if (n_found) begin
                        n_fx    = r_cx;
                        n_fz    = r_cz;
                        n_fh    = n_ch;
                        n_cx    = n_bx;
                        n_cz    = n_bz;
                        n_first = 1'b0;
                    end else begin
                        n_res              = '0;
                        n_res.from_x       = r_cx;
                        n_res.from_z       = r_cz;
                        n_res.from_height  = n_ch;
                        n_res.last_segment = 1'b1;
                        n_end              = 1'b1;
                    end
                end else begin
                    n_res.segment_valid = 1'b1;
                    n_res.from_x        = r_fx;
                    n_res.from_z        = r_fz;
                    n_res.from_height   = r_fh;
                    n_res.to_x          = r_cx;
                    n_res.to_z          = r_cz;
                    n_res.to_height     = n_ch;
                    n_res.truncated     = n_found && seg_last;
                    n_res.last_segment  = seg_last;
                    n_end               = seg_last;
                    n_count             = cnt1;
                    if (!seg_last) begin
                        n_fx = r_cx;
                        n_fz = r_cz;
                        n_fh = n_ch;
                        n_cx = n_bx;
                        n_cz = n_bz;
                    end
                end
            end
            default: begin
                n_end = r_end;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cen   <= 1'b0;
            r_pv    <= 1'b0;
            r_pc    <= 1'b0;
            r_first <= 1'b0;
            r_end   <= 1'b0;
            r_count <= '0;
            r_cx    <= '0;
            r_cz    <= '0;
        end else begin
            r_state <= n_state;
            r_cen   <= n_cen;
            r_pv    <= n_pv;
            r_pc    <= n_pc;
            r_first <= n_first;
            r_end   <= n_end;
            r_count <= n_count;
            r_cx    <= n_cx;
            r_cz    <= n_cz;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sx    <= n_sx;
        r_sz    <= n_sz;
        r_px    <= n_px;
        r_pz    <= n_pz;
        r_ch    <= n_ch;
        r_best  <= n_best;
        r_found <= n_found;
        r_bx    <= n_bx;
        r_bz    <= n_bz;
        r_fx    <= n_fx;
        r_fz    <= n_fz;
        r_fh    <= n_fh;
        r_res   <= n_res;
    end

endmodule

// ===== sv/steepest_descent_flow_trace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steepest_descent_flow_trace
// D8 steepest-descent flow tracer over a loaded height map.
// ----------------------------------------------------------------------------
// A trace walks downhill from its start cell and emits one transaction per
// move. Every step reads the current cell and its up to eight neighbors
// through the single read port of the height store, one sample per cycle:
// one center read, up to nine window positions and one compare drain, then
// an emit, except after a first step that finds a lower neighbor. A trace
// ends after at most 64 moves, and the output side can stall its emits. The
// block takes a new request once the previous trace has handed over its last
// result; that result may still wait in the output register.
// ----------------------------------------------------------------------------
module steepest_descent_flow_trace
    import sdft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // x_coord[7:0], z_coord[15:8], height_value[31:16]
    input  logic [0:0]  s_axis_tuser,  // req_type[0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // from_x[7:0], from_z[15:8], from_height[31:16],
                                       // to_x[39:32], to_z[47:40], to_height[63:48]
    output logic [1:0]  m_axis_tuser,  // segment_valid[0], truncated[1]
    output logic        m_axis_tlast,  // last_segment
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    logic [DIM_W-1:0] r_map_width, r_map_depth;
    logic [DIM_W-1:0] eff_width, eff_depth;

    t_ram_req                   ram_req;
    logic signed [HEIGHT_W-1:0] ram_rdata;
    logic                       core_push;
    t_result                    core_result;
    logic                       slot_free;

    logic    r_out_valid;
    t_result r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= 9'd256;
            r_map_depth <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH: r_map_width <= i_cfg_data;
                CFG_MAP_DEPTH: r_map_depth <= i_cfg_data;
                default:       r_map_width <= r_map_width;
            endcase
        end
    end

    // Map size clamped into the usable range; zero acts as one.
    always_comb begin
        eff_width = r_map_width;
        eff_depth = r_map_depth;
        if (r_map_width == '0) begin
            eff_width = DIM_W'(1);
        end else if (32'(r_map_width) > LIM_WIDTH) begin
            eff_width = DIM_W'(LIM_WIDTH);
        end
        if (r_map_depth == '0) begin
            eff_depth = DIM_W'(1);
        end else if (32'(r_map_depth) > LIM_DEPTH) begin
            eff_depth = DIM_W'(LIM_DEPTH);
        end
    end

    // Trace sequencer.
    sdft_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req_type  (s_axis_tuser[0]),
        .i_x         (s_axis_tdata[7:0]),
        .i_z         (s_axis_tdata[15:8]),
        .i_height    (s_axis_tdata[31:16]),
        .i_width     (eff_width),
        .i_depth     (eff_depth),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_push      (core_push),
        .o_result    (core_result),
        .i_slot_free (slot_free)
    );

    // Height store.
    sdft_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (MAP_CELLS)
    ) u_height_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // Output register between the sequencer and the result stream.
    assign slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_push && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_push && slot_free) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.to_height, r_out.to_z, r_out.to_x,
                            r_out.from_height, r_out.from_z, r_out.from_x};
    assign m_axis_tuser  = {r_out.truncated, r_out.segment_valid};
    assign m_axis_tlast  = r_out.last_segment;

`ifndef NO_ASSERTIONS
    // A result without a segment always closes its trace and is never truncated.
    a_noseg_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.segment_valid) |-> (r_out.last_segment && !r_out.truncated))
        else $error("no-segment result without last or with truncation");

    // Truncation is only flagged on the final segment.
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.truncated) |-> r_out.last_segment)
        else $error("truncated result is not the last of its trace");

    // The sequencer never pushes a result while it takes a request.
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_push |-> !s_axis_tready)
        else $error("result pushed while request port is ready");

    // A pushed result that finds the slot free shows up in the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_push && slot_free) |=> r_out_valid)
        else $error("pushed result lost");
`endif

endmodule
